@@ rtl/core/catrom_pkg.sv @@
package catrom_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  localparam int IDX_W = 6;
  localparam int W_W = 20;
  localparam int SPAN_W = 33;
  localparam int PROD_W = 54;
  localparam int DVD_W = 51;
  localparam int DVS_W = 33;
  localparam int T_W = 17;
  localparam int BAS_W = 52;
  localparam int W_MAX = 524287;
  localparam int W_MIN = -524288;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LO, ST_HI, ST_SRCH, ST_CMP, ST_X0, ST_X1, ST_XM, ST_XP,
    ST_TDIV, ST_MUL1, ST_MUL2, ST_BASIS, ST_AMUL, ST_ADIV, ST_AWAIT,
    ST_BMUL, ST_BDIV, ST_BWAIT, ST_FINAL
  } state_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Drops 32 fraction bits, rounding half away from zero.
  function automatic logic signed [W_W-1:0] round32(input logic signed [BAS_W-1:0] v);
    logic [BAS_W-1:0] m;
    logic [BAS_W-1:0] r;
    m = v[BAS_W-1] ? BAS_W'(-v) : BAS_W'(v);
    r = (m + (BAS_W'(1) << 31)) >> 32;
    return v[BAS_W-1] ? W_W'(-r) : W_W'(r);
  endfunction

  function automatic logic signed [W_W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(W_MAX)) begin
      return W_W'(W_MAX);
    end else if (v < PROD_W'(W_MIN)) begin
      return W_W'(W_MIN);
    end
    return W_W'(v);
  endfunction

endpackage

@@ rtl/core/catrom_if.sv @@
interface catrom_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [5:0]         node_index;
  logic signed [31:0] node_value;
  logic signed [31:0] query_x;
  modport source (output valid, req_type, node_index, node_value, query_x, input ready);
  modport sink (input valid, req_type, node_index, node_value, query_x, output ready);
endinterface

interface catrom_res_if;
  logic               valid;
  logic               ready;
  logic               in_range;
  logic signed [6:0]  offset;
  logic signed [19:0] weight_0;
  logic signed [19:0] weight_1;
  logic signed [19:0] weight_2;
  logic signed [19:0] weight_3;
  modport source (output valid, in_range, offset, weight_0, weight_1, weight_2, weight_3,
                  input ready);
  modport sink (input valid, in_range, offset, weight_0, weight_1, weight_2, weight_3,
                output ready);
endinterface

@@ rtl/core/catrom_ram.sv @@
module catrom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/catrom_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module catrom_div import catrom_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         ctl,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else if (ctl.start) begin
      sts.busy <= 1'b1;
      sts.done <= 1'b0;
      cnt      <= CW'(DVD_W);
    end else if (sts.busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        sts.busy <= 1'b0;
        sts.done <= 1'b1;
      end
    end else begin
      sts.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem      <= '0;
      dvs      <= ctl.divisor;
      quotient <= ctl.dividend;
    end else if (sts.busy) begin
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end
endmodule

@@ rtl/core/catmull_rom_spline_weights.sv @@
// Channel | Direction | Payload
// req     | in        | req_type, node_index, node_value, query_x
// res     | out       | in_range, offset, weight_0..weight_3
// cfg     | in        | cfg_en, cfg_data (node_count)
//
// A load transaction leaves the block idle. A query reads the table:
// two end reads, up to six search reads and four neighbor reads.
// An in-range query then uses the shared one-bit-per-cycle divider up to three
// times, 51 quotient bits each; an out-of-range query skips the search and
// the divider.
// Reset idles the FSM, sets node_count to 2; the table is undefined until loaded.
// A finished result waits in the output register while the next request is taken.
module catmull_rom_spline_weights import catrom_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [CNT_W-1:0] cfg_data,
  catrom_req_if.sink       req,
  catrom_res_if.source     res
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int TABLE_LIMIT = (MAX_NODES < 64) ? MAX_NODES : 64;

  state_t state, state_next;

  logic [CNT_W-1:0]        node_count;
  logic [CNT_W-1:0]        n_use;
  logic signed [VAL_W-1:0] rd;
  logic [AW-1:0]           raddr;
  logic                    mem_we;
  div_req_t                div_ctl;
  div_sts_t                div_sts;
  logic [DVD_W-1:0]        quo;

  logic signed [VAL_W-1:0] x, x0, x1, xm, xp;
  logic                    lo_ok, in_rng;
  logic [CNT_W-1:0]        first, size;
  logic [IDX_W-1:0]        idx;
  logic signed [SPAN_W-1:0] num, den, span;
  logic [T_W-1:0]          t;
  logic [32:0]             t2;
  logic [48:0]             t3;
  logic signed [W_W-1:0]   h00, h01, h10, h11;
  logic signed [PROD_W-1:0] prod;
  logic                    neg;
  logic signed [BAS_W-1:0] a, b;

  logic                    accept;
  logic [CNT_W-1:0]        half;
  logic                    has_m, has_p;
  logic [DVS_W-1:0]        ad;
  logic [PROD_W-1:0]       an;
  logic [33:0]             t_sq;
  logic [49:0]             t_cu;
  logic signed [52:0]      pa, pb;
  logic signed [BAS_W-1:0] t3s, t2s, t1s, one48, h00f, h10f, h11f;
  logic signed [PROD_W-1:0] w0, w1, w2, w3;

  assign accept = req.valid && req.ready;
  assign half   = size >> 1;
  assign has_m  = idx != '0;
  assign has_p  = (CNT_W'(idx) + CNT_W'(2)) < n_use;
  assign ad     = span[SPAN_W-1] ? DVS_W'(-span) : DVS_W'(span);
  assign an     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign t_sq   = 34'(t) * 34'(t);
  assign t_cu   = 50'(t2) * 50'(t);
  assign pa     = 53'(h10) * 53'(den);
  assign pb     = 53'(h11) * 53'(den);

  always_comb begin
    if (node_count < CNT_W'(2)) begin
      n_use = CNT_W'(2);
    end else if (node_count > CNT_W'(TABLE_LIMIT)) begin
      n_use = CNT_W'(TABLE_LIMIT);
    end else begin
      n_use = node_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(2);
    end else if (cfg_en) begin
      node_count <= cfg_data;
    end
  end

  assign mem_we = accept && (req.req_type == REQ_LOAD) && (int'(req.node_index) < MAX_NODES);

  catrom_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(req.node_index)),
    .wdata (req.node_value),
    .raddr (raddr),
    .rdata (rd)
  );

  catrom_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .sts      (div_sts),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    div_ctl    = '0;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.req_type == REQ_QUERY) begin
          state_next = ST_LO;
        end
      end
      ST_LO: begin
        raddr      = AW'(n_use - 1'b1);
        state_next = ST_HI;
      end
      ST_HI: begin
        state_next = (lo_ok && x <= rd) ? ST_SRCH : ST_FINAL;
      end
      ST_SRCH: begin
        if (size != '0) begin
          raddr      = AW'(first + half);
          state_next = ST_CMP;
        end else begin
          raddr      = AW'(first - 1'b1);
          state_next = ST_X0;
        end
      end
      ST_CMP: state_next = ST_SRCH;
      ST_X0: begin
        raddr      = AW'(CNT_W'(idx) + CNT_W'(1));
        state_next = ST_X1;
      end
      ST_X1: begin
        raddr      = has_m ? AW'(CNT_W'(idx) - CNT_W'(1)) : '0;
        state_next = ST_XM;
      end
      ST_XM: begin
        raddr      = has_p ? AW'(CNT_W'(idx) + CNT_W'(2)) : '0;
        state_next = ST_XP;
      end
      ST_XP: begin
        if (den > 0 && num > 0 && num < den) begin
          div_ctl.start    = 1'b1;
          div_ctl.dividend = DVD_W'({num[31:0], 16'h0000});
          div_ctl.divisor  = DVS_W'(den);
          state_next       = ST_TDIV;
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_TDIV: if (div_sts.done) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_BASIS;
      ST_BASIS: state_next = ST_AMUL;
      ST_AMUL: state_next = ST_ADIV;
      ST_ADIV: begin
        if (has_m && span != '0) begin
          div_ctl.start    = 1'b1;
          div_ctl.dividend = DVD_W'(an) + DVD_W'(ad >> 1);
          div_ctl.divisor  = ad;
          state_next       = ST_AWAIT;
        end else begin
          state_next = ST_BMUL;
        end
      end
      ST_AWAIT: if (div_sts.done) state_next = ST_BMUL;
      ST_BMUL: state_next = ST_BDIV;
      ST_BDIV: begin
        if (has_p && span != '0) begin
          div_ctl.start    = 1'b1;
          div_ctl.dividend = DVD_W'(an) + DVD_W'(ad >> 1);
          div_ctl.divisor  = ad;
          state_next       = ST_BWAIT;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_BWAIT: if (div_sts.done) state_next = ST_FINAL;
      ST_FINAL: if (!res.valid || res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Hermite basis in Q.48.
  always_comb begin
    one48 = BAS_W'(1) << 48;
    t3s   = signed'(BAS_W'(t3));
    t2s   = signed'(BAS_W'(t2) << 16);
    t1s   = signed'(BAS_W'(t) << 32);
    h00f  = (t3s <<< 1) - t2s - (t2s <<< 1) + one48;
    h10f  = t3s - (t2s <<< 1) + t1s;
    h11f  = t3s - t2s;
  end

  always_comb begin
    w0 = has_m ? -PROD_W'(a) : '0;
    w1 = PROD_W'(h00) - (has_m ? PROD_W'(0) : PROD_W'(h10))
         - (has_p ? PROD_W'(b) : PROD_W'(h11));
    w2 = PROD_W'(h01) + (has_m ? PROD_W'(a) : PROD_W'(h10))
         + (has_p ? PROD_W'(0) : PROD_W'(h11));
    w3 = has_p ? PROD_W'(b) : '0;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:  x <= req.query_x;
      ST_LO:    lo_ok <= x >= rd;
      ST_HI: begin
        in_rng <= lo_ok && x <= rd;
        first  <= CNT_W'(1);
        size   <= n_use - CNT_W'(2);
      end
      ST_SRCH:  idx <= IDX_W'(first - 1'b1);
      ST_CMP: begin
        if (rd <= x) begin
          first <= first + half + 1'b1;
          size  <= size - half - 1'b1;
        end else begin
          size <= half;
        end
      end
      ST_X0: begin
        x0  <= rd;
        num <= SPAN_W'(x) - SPAN_W'(rd);
      end
      ST_X1: begin
        x1  <= rd;
        den <= SPAN_W'(rd) - SPAN_W'(x0);
      end
      ST_XM:    xm <= rd;
      ST_XP: begin
        xp <= rd;
        t  <= (den > 0 && num > 0 && num >= den) ? T_W'(65536) : '0;
      end
      ST_TDIV:  if (div_sts.done) t <= T_W'(quo);
      ST_MUL1:  t2 <= t_sq[32:0];
      ST_MUL2:  t3 <= t_cu[48:0];
      ST_BASIS: begin
        h00 <= round32(h00f);
        h01 <= round32(one48 - h00f);
        h10 <= round32(h10f);
        h11 <= round32(h11f);
      end
      ST_AMUL: begin
        prod <= PROD_W'(pa);
        span <= SPAN_W'(x1) - SPAN_W'(xm);
        a    <= '0;
      end
      ST_ADIV:  neg <= prod[PROD_W-1] != span[SPAN_W-1];
      ST_AWAIT: if (div_sts.done) a <= neg ? -BAS_W'(quo) : BAS_W'(quo);
      ST_BMUL: begin
        prod <= PROD_W'(pb);
        span <= SPAN_W'(xp) - SPAN_W'(x0);
        b    <= '0;
      end
      ST_BDIV:  neg <= prod[PROD_W-1] != span[SPAN_W-1];
      ST_BWAIT: if (div_sts.done) b <= neg ? -BAS_W'(quo) : BAS_W'(quo);
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_FINAL && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL && (!res.valid || res.ready)) begin
      res.in_range <= in_rng;
      res.offset   <= in_rng ? 7'(CNT_W'(idx) - CNT_W'(1)) : '0;
      res.weight_0 <= in_rng ? sat_w(w0) : '0;
      res.weight_1 <= in_rng ? sat_w(w1) : '0;
      res.weight_2 <= in_rng ? sat_w(w2) : '0;
      res.weight_3 <= in_rng ? sat_w(w3) : '0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == ST_IDLE) else $error("request taken outside idle");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_QUERY |=> state == ST_LO)
    else $error("query transaction did not start a lookup");

  a_res_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ST_FINAL)) else $error("result without a finished query");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy) else $error("divider started while busy");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_LOAD |=> state == ST_IDLE)
    else $error("load transaction left idle");
endmodule
